// ===== sv/isd_pkg.sv =====
// ----------------------------------------------------------------------------
// isd_pkg: shared types and constants for the include directive scanner
// Parse states, result kinds, the result word and the character codes.
// ----------------------------------------------------------------------------
package isd_pkg;

  typedef enum logic [10:0] {
    PS_HASH   = 11'h001,
    PS_KEY_I  = 11'h002,
    PS_KEY_N  = 11'h004,
    PS_KEY_C  = 11'h008,
    PS_KEY_L  = 11'h010,
    PS_KEY_U  = 11'h020,
    PS_KEY_D  = 11'h040,
    PS_KEY_E  = 11'h080,
    PS_OPEN   = 11'h100,
    PS_NAME   = 11'h200,
    PS_IGNORE = 11'h400
  } parse_state_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } result_kind_e;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   name_byte;
    logic         overflow;
  } result_t;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;

endpackage

// ===== sv/isd_scan.sv =====
// ----------------------------------------------------------------------------
// isd_scan: directive parser
// Holds the parse state and the name length; makes at most one result per byte.
// ----------------------------------------------------------------------------
module isd_scan #(
  parameter int MAX_NAME = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_stream_i,
  output logic             res_valid_o,
  output isd_pkg::result_t res_o
);

  localparam int LenW = $clog2(MAX_NAME + 2);
  localparam logic [LenW-1:0] MaxLen   = LenW'(MAX_NAME);
  localparam logic [LenW-1:0] MaxLenP1 = LenW'(MAX_NAME + 1);

  isd_pkg::parse_state_e state_q, state_d, kw_next;
  logic [LenW-1:0]       len_q, len_d;
  logic                  blank, newline, closing;

  assign blank   = (in_byte_i == isd_pkg::CH_SPACE) || (in_byte_i == isd_pkg::CH_TAB);
  assign newline = (in_byte_i == isd_pkg::CH_NL);
  assign closing = (in_byte_i == isd_pkg::CH_QUOTE) || (in_byte_i == isd_pkg::CH_LT) ||
                   (in_byte_i == isd_pkg::CH_GT);

  // keyword follower
  always_comb begin
    kw_next = isd_pkg::PS_IGNORE;
    case (state_q)
      isd_pkg::PS_HASH: begin
        if (in_byte_i == isd_pkg::CH_HASH) kw_next = isd_pkg::PS_KEY_I;
        else if (blank)                    kw_next = isd_pkg::PS_HASH;
      end
      isd_pkg::PS_KEY_I: begin
        if (in_byte_i == isd_pkg::CH_I) kw_next = isd_pkg::PS_KEY_N;
        else if (blank)                 kw_next = isd_pkg::PS_KEY_I;
      end
      isd_pkg::PS_KEY_N: if (in_byte_i == isd_pkg::CH_N) kw_next = isd_pkg::PS_KEY_C;
      isd_pkg::PS_KEY_C: if (in_byte_i == isd_pkg::CH_C) kw_next = isd_pkg::PS_KEY_L;
      isd_pkg::PS_KEY_L: if (in_byte_i == isd_pkg::CH_L) kw_next = isd_pkg::PS_KEY_U;
      isd_pkg::PS_KEY_U: if (in_byte_i == isd_pkg::CH_U) kw_next = isd_pkg::PS_KEY_D;
      isd_pkg::PS_KEY_D: if (in_byte_i == isd_pkg::CH_D) kw_next = isd_pkg::PS_KEY_E;
      isd_pkg::PS_KEY_E: begin
        if (in_byte_i == isd_pkg::CH_E) kw_next = isd_pkg::PS_OPEN;
        else if (blank)                 kw_next = isd_pkg::PS_KEY_E;
      end
      isd_pkg::PS_OPEN: begin
        if (in_byte_i == isd_pkg::CH_I)                                kw_next = isd_pkg::PS_KEY_N;
        else if ((in_byte_i == isd_pkg::CH_QUOTE) ||
                 (in_byte_i == isd_pkg::CH_LT))                        kw_next = isd_pkg::PS_NAME;
        else if (blank)                                                kw_next = isd_pkg::PS_OPEN;
      end
      default: kw_next = isd_pkg::PS_IGNORE;
    endcase
  end

  always_comb begin
    state_d             = state_q;
    len_d               = len_q;
    res_valid_o         = 1'b0;
    res_o.kind          = isd_pkg::KIND_BYTE;
    res_o.name_byte     = 8'h00;
    res_o.overflow      = 1'b0;
    if (end_of_stream_i) begin
      state_d     = isd_pkg::PS_HASH;
      len_d       = '0;
      res_valid_o = 1'b1;
      res_o.kind  = isd_pkg::KIND_ABORT;
    end else if (state_q == isd_pkg::PS_NAME) begin
      if (newline) begin
        // newline inside a name is dropped
      end else if (closing) begin
        state_d        = isd_pkg::PS_IGNORE;
        len_d          = '0;
        res_valid_o    = 1'b1;
        res_o.kind     = isd_pkg::KIND_DONE;
        res_o.overflow = (len_q > MaxLen);
      end else if (len_q < MaxLen) begin
        len_d           = len_q + 1'b1;
        res_valid_o     = 1'b1;
        res_o.name_byte = in_byte_i;
      end else begin
        len_d = MaxLenP1;
      end
    end else if (newline) begin
      // a partial directive may continue on the next line
      case (state_q)
        isd_pkg::PS_HASH, isd_pkg::PS_KEY_I, isd_pkg::PS_KEY_N, isd_pkg::PS_KEY_C,
        isd_pkg::PS_KEY_L, isd_pkg::PS_KEY_U, isd_pkg::PS_KEY_D, isd_pkg::PS_KEY_E,
        isd_pkg::PS_OPEN: state_d = state_q;
        default:          state_d = isd_pkg::PS_HASH;
      endcase
    end else begin
      state_d = kw_next;
      if (kw_next == isd_pkg::PS_NAME) len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isd_pkg::PS_HASH;
      len_q   <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

endmodule

// ===== sv/isd_outbuf.sv =====
// ----------------------------------------------------------------------------
// isd_outbuf: two-entry result buffer
// Output register plus skid entry, so input ready never waits on output ready.
// ----------------------------------------------------------------------------
module isd_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  isd_pkg::result_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_ready_i,
  output isd_pkg::result_t data_o
);

  logic [1:0]       count_q, count_d;
  isd_pkg::result_t head_q, tail_q;
  logic             pop;

  assign pop     = valid_o && pop_ready_i;
  assign valid_o = (count_q != 2'd0);
  assign ready_o = (count_q != 2'd2);
  assign data_o  = head_q;

  always_comb begin
    count_d = count_q;
    case (count_q)
      2'd0:    if (push_i) count_d = 2'd1;
      2'd1: begin
        if (push_i && !pop)      count_d = 2'd2;
        else if (pop && !push_i) count_d = 2'd0;
      end
      2'd2:    if (pop) count_d = 2'd1;
      default: count_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (count_q == 2'd2) begin
      if (pop) head_q <= tail_q;
    end else if (push_i) begin
      if (count_q == 2'd0 || pop) head_q <= data_i;
      else                        tail_q <= data_i;
    end
  end

endmodule

// ===== sv/include_directive_scanner.sv =====
// ----------------------------------------------------------------------------
// include_directive_scanner: include directive name extractor
// Finds #include "name" / <name> lines in a byte stream and emits the name.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle, back to back, while the buffer has room, and
// its result is registered in the result buffer. Each byte causes at most one
// result: a name byte, a name-complete word (with overflow flag once the name
// passed MAX_NAME bytes) or a stream-ended word when end_of_stream_i is set.
// The input stays ready while the two-entry result buffer has room, so it
// only stalls once two result words are waiting at the output.
module include_directive_scanner #(
  parameter int MAX_NAME = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] name_byte_o,
  output logic       name_overflow_o
);

  logic             step, res_valid;
  isd_pkg::result_t res, head;

  assign step = in_valid_i && in_ready_o;

  isd_scan #(
    .MAX_NAME(MAX_NAME)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .in_byte_i      (in_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  isd_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (step && res_valid),
    .data_i     (res),
    .ready_o    (in_ready_o),
    .valid_o    (out_valid_o),
    .pop_ready_i(out_ready_i),
    .data_o     (head)
  );

  assign result_kind_o   = head.kind;
  assign name_byte_o     = head.name_byte;
  assign name_overflow_o = head.overflow;

endmodule

// ===== sv/isd_checker.sv =====
// ----------------------------------------------------------------------------
// isd_checker: port-level checks for the include directive scanner
// Watches the handshakes and result words over time.
// ----------------------------------------------------------------------------
module isd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       end_of_stream_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] result_kind_o,
  input logic [7:0] name_byte_o,
  input logic       name_overflow_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(name_byte_o) && $stable(name_overflow_o))
    else $error("result word changed while stalled");

  // an end of stream always leaves a result waiting
  a_eos_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && end_of_stream_i |=> out_valid_o)
    else $error("end of stream gave no result");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o != isd_pkg::KIND_BYTE) |-> name_byte_o == 8'h00)
    else $error("name byte set on a non-byte result");

  a_ovf_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o != isd_pkg::KIND_DONE) |-> !name_overflow_o)
    else $error("overflow set outside completion");

  // input only stalls when the buffer holds results
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind include_directive_scanner isd_checker u_isd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .end_of_stream_i(end_of_stream_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_kind_o  (result_kind_o),
  .name_byte_o    (name_byte_o),
  .name_overflow_o(name_overflow_o)
);

// ===== tb/sv/include_directive_scanner_tb.sv =====
// ----------------------------------------------------------------------------
// include_directive_scanner_tb: self-checking bench for the include scanner
// Streams source text into the scanner and checks every name byte, completion
// and stream-ended word against a cycle-free model of the parse state machine.
// Covers directed corner cases, overlong names, output backpressure that stalls
// the input, and a long random run of directives mixed with noise.
// ----------------------------------------------------------------------------
module include_directive_scanner_tb;

  localparam int MAX_NAME   = 255;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN   = 200;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_eos;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] result_kind;
  logic [7:0] name_byte;
  logic       name_overflow;

  // scanner model state
  isd_pkg::parse_state_e scan_state;
  int unsigned           scan_len;
  isd_pkg::result_t      pending_words[$];

  bit gaps_on;
  bit hold_req;
  int errors;
  int bytes_sent;
  int words_seen;
  int names_done;
  int streams_ended;
  int overflows;
  int idle_cycles;

  include_directive_scanner #(
    .MAX_NAME(MAX_NAME)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_byte_i      (in_byte),
    .end_of_stream_i(in_eos),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_o  (result_kind),
    .name_byte_o    (name_byte),
    .name_overflow_o(name_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // advance the scanner model by one byte; returns 1 when a word comes out
  function automatic bit scan_step(input logic [7:0] b, input logic eos,
                                   output isd_pkg::result_t word);
    bit blank;
    blank = (b == isd_pkg::CH_SPACE) || (b == isd_pkg::CH_TAB);
    word.kind = isd_pkg::KIND_BYTE;
    word.name_byte = 8'h00;
    word.overflow = 1'b0;
    if (eos) begin
      scan_state = isd_pkg::PS_HASH;
      scan_len = 0;
      word.kind = isd_pkg::KIND_ABORT;
      return 1'b1;
    end
    if (scan_state == isd_pkg::PS_NAME) begin
      if (b == isd_pkg::CH_NL) return 1'b0;
      if (b == isd_pkg::CH_QUOTE || b == isd_pkg::CH_LT || b == isd_pkg::CH_GT) begin
        word.kind = isd_pkg::KIND_DONE;
        word.overflow = (scan_len > MAX_NAME);
        scan_state = isd_pkg::PS_IGNORE;
        scan_len = 0;
        return 1'b1;
      end
      if (scan_len < MAX_NAME) begin
        scan_len++;
        word.name_byte = b;
        return 1'b1;
      end
      scan_len = MAX_NAME + 1;
      return 1'b0;
    end
    // newline keeps a partial directive alive
    if (b == isd_pkg::CH_NL) begin
      if (scan_state == isd_pkg::PS_IGNORE) scan_state = isd_pkg::PS_HASH;
      return 1'b0;
    end
    case (scan_state)
      isd_pkg::PS_HASH:
        scan_state = (b == isd_pkg::CH_HASH) ? isd_pkg::PS_KEY_I :
                     (blank ? isd_pkg::PS_HASH : isd_pkg::PS_IGNORE);
      isd_pkg::PS_KEY_I:
        scan_state = (b == isd_pkg::CH_I) ? isd_pkg::PS_KEY_N :
                     (blank ? isd_pkg::PS_KEY_I : isd_pkg::PS_IGNORE);
      isd_pkg::PS_KEY_N:
        scan_state = (b == isd_pkg::CH_N) ? isd_pkg::PS_KEY_C : isd_pkg::PS_IGNORE;
      isd_pkg::PS_KEY_C:
        scan_state = (b == isd_pkg::CH_C) ? isd_pkg::PS_KEY_L : isd_pkg::PS_IGNORE;
      isd_pkg::PS_KEY_L:
        scan_state = (b == isd_pkg::CH_L) ? isd_pkg::PS_KEY_U : isd_pkg::PS_IGNORE;
      isd_pkg::PS_KEY_U:
        scan_state = (b == isd_pkg::CH_U) ? isd_pkg::PS_KEY_D : isd_pkg::PS_IGNORE;
      isd_pkg::PS_KEY_D:
        scan_state = (b == isd_pkg::CH_D) ? isd_pkg::PS_KEY_E : isd_pkg::PS_IGNORE;
      isd_pkg::PS_KEY_E:
        scan_state = (b == isd_pkg::CH_E) ? isd_pkg::PS_OPEN :
                     (blank ? isd_pkg::PS_KEY_E : isd_pkg::PS_IGNORE);
      isd_pkg::PS_OPEN: begin
        if (b == isd_pkg::CH_I) scan_state = isd_pkg::PS_KEY_N;
        else if (b == isd_pkg::CH_QUOTE || b == isd_pkg::CH_LT) scan_state = isd_pkg::PS_NAME;
        else scan_state = blank ? isd_pkg::PS_OPEN : isd_pkg::PS_IGNORE;
      end
      default: scan_state = isd_pkg::PS_IGNORE;
    endcase
    if (scan_state == isd_pkg::PS_NAME) scan_len = 0;
    return 1'b0;
  endfunction

  // drive one byte at the falling edge and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic eos);
    isd_pkg::result_t word;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_eos   <= eos;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (scan_step(b, eos, word)) pending_words.push_back(word);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_blanks(input int max_count);
    repeat ($urandom_range(0, max_count))
      send_byte($urandom_range(0, 1) ? isd_pkg::CH_SPACE : isd_pkg::CH_TAB, 1'b0);
  endtask

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 10))
      0:       return isd_pkg::CH_HASH;
      1:       return isd_pkg::CH_LT;
      2:       return isd_pkg::CH_GT;
      3:       return isd_pkg::CH_QUOTE;
      4:       return isd_pkg::CH_SPACE;
      5:       return isd_pkg::CH_TAB;
      6:       return isd_pkg::CH_NL;
      7:       return isd_pkg::CH_I;
      8:       return isd_pkg::CH_E;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_close();
    case ($urandom_range(0, 2))
      0:       return isd_pkg::CH_QUOTE;
      1:       return isd_pkg::CH_LT;
      default: return isd_pkg::CH_GT;
    endcase
  endfunction

  // one directive with random spacing, name and line tail, or cut off by end of stream
  task automatic send_directive(input int name_len);
    string key;
    key = "includ";
    send_blanks(2);
    send_byte(isd_pkg::CH_HASH, 1'b0);
    send_blanks(2);
    for (int i = 0; i < key.len(); i++) begin
      send_byte(key[i], 1'b0);
      if ($urandom_range(0, 15) == 0) send_byte(isd_pkg::CH_NL, 1'b0);
    end
    send_blanks(1);
    send_byte(isd_pkg::CH_E, 1'b0);
    send_blanks(2);
    // keyword may start over from the open state
    if ($urandom_range(0, 9) == 0) begin
      send_text("include");
      send_blanks(1);
    end
    send_byte($urandom_range(0, 1) ? isd_pkg::CH_QUOTE : isd_pkg::CH_LT, 1'b0);
    repeat (name_len) begin
      if ($urandom_range(0, 14) == 0) send_byte(isd_pkg::CH_NL, 1'b0);
      else if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
      else send_byte(8'($urandom_range(8'h2E, 8'h7A)), 1'b0);
    end
    if ($urandom_range(0, 9) == 0) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_byte(pick_close(), 1'b0);
      repeat ($urandom_range(0, 4)) send_byte(pick_special(), 1'b0);
      send_byte(isd_pkg::CH_NL, 1'b0);
    end
  endtask

  // random bytes, truncated keywords and stray end of stream
  task automatic send_noise();
    if ($urandom_range(0, 2) == 0) send_text("#inc");
    repeat ($urandom_range(1, 10)) begin
      if ($urandom_range(0, 11) == 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
      else if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
      else send_byte(pick_special(), 1'b0);
    end
  endtask

  task automatic test_directed();
    // directive on the very first line, split over a newline, blank before e
    send_text("\t#incl\nud e<");
    send_byte(8'hFF, 1'b0);
    send_byte(isd_pkg::CH_NL, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(isd_pkg::CH_QUOTE, 1'b0);
    send_byte(8'hFF, 1'b1);
    // empty name right after stream end
    send_text("#include\"\"");
    send_byte(isd_pkg::CH_NL, 1'b0);
  endtask

  task automatic test_overlong_name();
    int lens[3];
    lens = '{MAX_NAME, MAX_NAME + 1, MAX_NAME + 20};
    foreach (lens[k]) begin
      send_text("#include<");
      repeat (lens[k])
        send_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A)) :
                  8'($urandom_range(8'h80, 8'hFF)), 1'b0);
      send_byte(isd_pkg::CH_GT, 1'b0);
      send_byte(isd_pkg::CH_NL, 1'b0);
    end
    // abort in the middle of an overlong name
    send_text("#include\"");
    repeat (MAX_NAME + 5) send_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    send_directive(40);
    send_directive(10);
  endtask

  task automatic test_random(input int count);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      if (bytes_sent - start > count * 4 / 5) gaps_on = 1'b0;
      if ($urandom_range(0, 9) < 7)
        send_directive(($urandom_range(0, 19) == 0) ? $urandom_range(13, 60) :
                       $urandom_range(0, 12));
      else
        send_noise();
    end
  endtask

  // receiver: random stall bursts plus one long hold on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker and no-progress counter
  always @(posedge clk) begin
    isd_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (pending_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word kind %0d byte %02h ovf %0d", $time,
                   result_kind, name_byte, name_overflow);
        end else begin
          want = pending_words.pop_front();
          if (result_kind !== want.kind || name_byte !== want.name_byte ||
              name_overflow !== want.overflow) begin
            errors++;
            $display("%0t: expected kind %0d byte %02h ovf %0d, actual kind %0d byte %02h ovf %0d",
                     $time, want.kind, want.name_byte, want.overflow,
                     result_kind, name_byte, name_overflow);
          end
          if (want.kind == isd_pkg::KIND_DONE) names_done++;
          if (want.kind == isd_pkg::KIND_ABORT) streams_ended++;
          if (want.overflow) overflows++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    in_eos = 1'b0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    errors = 0;
    bytes_sent = 0;
    words_seen = 0;
    names_done = 0;
    streams_ended = 0;
    overflows = 0;
    idle_cycles = 0;
    scan_state = isd_pkg::PS_HASH;
    scan_len = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_overlong_name();
    test_backpressure();
    test_random(300);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes, checked %0d words: %0d names, %0d stream ends, %0d overflows",
             bytes_sent, words_seen, names_done, streams_ended, overflows);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
